@@ rtl/cor_pkg.sv @@
// Shared constants, types and arithmetic helpers of the circle overlap repulsion block.
package cor_pkg;

  localparam int MAX_CIRCLES = 64;
  localparam int ADDR_W      = $clog2(MAX_CIRCLES);
  localparam int CNT_W       = $clog2(MAX_CIRCLES + 1);

  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int POS_W      = 24;
  localparam int RAD_W      = 20;
  localparam int NUM_W      = 7;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int DIF_W  = POS_W + 1;
  localparam int RS_W   = RAD_W + 1;
  localparam int UPD_W  = POS_W + 2;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELAX = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CIRCLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1966;

  // One table entry as stored in the circle memory.
  typedef struct packed {
    logic                    collides;
    logic [RAD_W-1:0]        radius;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } circ_t;

  // Floor of (+/- magnitude * gain) / 2^16, given the unsigned product.
  function automatic logic signed [DIF_W-1:0] push_amt(input logic [PROD_W-1:0] prod,
                                                       input logic neg);
    logic [PROD_W:0]  up;
    logic [DIF_W-1:0] mag;
    up = {1'b0, prod} + {{(PROD_W - 15){1'b0}}, 16'hFFFF};
    if (neg) begin
      mag = up[DIF_W+15:16];
      push_amt = -$signed(mag);
    end else begin
      mag = prod[DIF_W+15:16];
      push_amt = $signed(mag);
    end
  endfunction

  // Clamp a widened coordinate to the signed position range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [UPD_W-1:0] v);
    if (v[UPD_W-1:POS_W-1] == '0 || v[UPD_W-1:POS_W-1] == '1) begin
      sat_pos = v[POS_W-1:0];
    end else if (v[UPD_W-1]) begin
      sat_pos = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      sat_pos = {1'b0, {(POS_W - 1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/circle_overlap_repulsion_pass.sv @@
// Top level: circle table, pair sequencer and shared multiplier for overlap repulsion.
// Write and undefined operations: result registered at the accepting edge.
// Read: the entry passes the registered read port of the circle memory, then the result register.
// Relax with n circles in use: per row i < n-1, read and load i, write back if it collides;
//   pairs of a colliding i: read j; if it collides, square and compare; on overlap push apart.
// One item at a time; the next item is taken once the result slot is free or being drained.
// Reset (synchronous, rst_n low) clears control and restores both registers; the table is kept.
module circle_overlap_repulsion_pass (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cor_pkg::OP_W-1:0]          in_operation,
  input  logic [cor_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [cor_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [cor_pkg::POS_W-1:0]  in_pos_y,
  input  logic [cor_pkg::RAD_W-1:0]         in_radius,
  input  logic                              in_collides,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cor_pkg::IDX_W-1:0]         out_index,
  output logic signed [cor_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [cor_pkg::POS_W-1:0]  out_pos_y,
  output logic [cor_pkg::OP_W-1:0]          out_op_done,
  input  logic                              cfg_wr_en,
  input  logic [cor_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cor_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cor_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDOUT, S_ROW, S_RDI, S_LDI, S_RDJ, S_DIFF, S_SQX,
    S_SQY, S_SQR, S_CMP, S_GX, S_GY, S_UPD, S_WBI, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_W-1:0]  cfg_n_r;
  logic [GAIN_W-1:0] gain_r;
  logic [CNT_W-1:0]  n_use;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] i_inc, j_inc;
  circ_t            cur_r, cur_nxt, oth_r, oth_nxt;
  logic [MUL_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic             sx_r, sx_nxt, sy_r, sy_nxt;
  logic [RS_W-1:0]  rs_r, rs_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [DIF_W-1:0] px_r, px_nxt, py_r, py_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_index_r, out_index_nxt;
  logic signed [POS_W-1:0] out_pos_x_r, out_pos_x_nxt, out_pos_y_r, out_pos_y_nxt;
  logic [OP_W-1:0]         out_op_r, out_op_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  circ_t             ram_wdata, ram_rdata;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  logic signed [DIF_W-1:0] dx, dy;
  logic signed [POS_W-1:0] xi_new, yi_new, xj_new, yj_new;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_n_r <= '0;
      gain_r  <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CIRCLES: cfg_n_r <= cfg_wdata[NUM_W-1:0];
        CFG_GAIN:    gain_r  <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(cfg_n_r) > MAX_CIRCLES) begin
      n_use = CNT_W'(MAX_CIRCLES);
    end else begin
      n_use = CNT_W'(cfg_n_r);
    end
  end

  assign i_inc = i_r + CNT_W'(1);
  assign j_inc = j_r + CNT_W'(1);

  assign dx = {ram_rdata.pos_x[POS_W-1], ram_rdata.pos_x} - {cur_r.pos_x[POS_W-1], cur_r.pos_x};
  assign dy = {ram_rdata.pos_y[POS_W-1], ram_rdata.pos_y} - {cur_r.pos_y[POS_W-1], cur_r.pos_y};

  assign xi_new = sat_pos({{2{cur_r.pos_x[POS_W-1]}}, cur_r.pos_x} - {px_r[DIF_W-1], px_r});
  assign yi_new = sat_pos({{2{cur_r.pos_y[POS_W-1]}}, cur_r.pos_y} - {py_r[DIF_W-1], py_r});
  assign xj_new = sat_pos({{2{oth_r.pos_x[POS_W-1]}}, oth_r.pos_x} + {px_r[DIF_W-1], px_r});
  assign yj_new = sat_pos({{2{oth_r.pos_y[POS_W-1]}}, oth_r.pos_y} + {py_r[DIF_W-1], py_r});

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);

  // Operand selection for the shared multiplier; the product is registered and appears in the next cycle.
  always_comb begin
    case (state_r)
      S_SQX: begin
        mul_a = mx_r;
        mul_b = mx_r;
      end
      S_SQY: begin
        mul_a = my_r;
        mul_b = my_r;
      end
      S_SQR: begin
        mul_a = MUL_W'(rs_r);
        mul_b = MUL_W'(rs_r);
      end
      S_CMP: begin
        mul_a = mx_r;
        mul_b = MUL_W'(gain_r);
      end
      S_GX: begin
        mul_a = my_r;
        mul_b = MUL_W'(gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      S_RDI:   ram_raddr = i_r[ADDR_W-1:0];
      S_RDJ:   ram_raddr = j_r[ADDR_W-1:0];
      default: ram_raddr = ADDR_W'(in_entry_index);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    oth_nxt       = oth_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    rs_nxt        = rs_r;
    acc_nxt       = acc_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_pos_x_nxt = out_pos_x_r;
    out_pos_y_nxt = out_pos_y_r;
    out_op_nxt    = out_op_r;
    ram_we        = 1'b0;
    ram_waddr     = i_r[ADDR_W-1:0];
    ram_wdata     = cur_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_operation)
            OP_WRITE: begin
              ram_we           = int'(in_entry_index) < MAX_CIRCLES;
              ram_waddr        = ADDR_W'(in_entry_index);
              ram_wdata.pos_x  = in_pos_x;
              ram_wdata.pos_y  = in_pos_y;
              ram_wdata.radius = in_radius;
              ram_wdata.collides = in_collides;
              out_valid_nxt    = 1'b1;
              out_index_nxt    = in_entry_index;
              out_pos_x_nxt    = '0;
              out_pos_y_nxt    = '0;
              out_op_nxt       = OP_WRITE;
            end
            OP_RELAX: begin
              i_nxt     = '0;
              state_nxt = S_ROW;
            end
            OP_READ: begin
              idx_nxt   = in_entry_index;
              state_nxt = S_RDOUT;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_index_nxt = '0;
              out_pos_x_nxt = '0;
              out_pos_y_nxt = '0;
              out_op_nxt    = in_operation;
            end
          endcase
        end
      end
      S_RDOUT: begin
        out_valid_nxt = 1'b1;
        out_index_nxt = idx_r;
        out_op_nxt    = OP_READ;
        if (int'(idx_r) < MAX_CIRCLES) begin
          out_pos_x_nxt = ram_rdata.pos_x;
          out_pos_y_nxt = ram_rdata.pos_y;
        end else begin
          out_pos_x_nxt = '0;
          out_pos_y_nxt = '0;
        end
        state_nxt = S_IDLE;
      end
      S_ROW: begin
        // The last entry in use has no partner after it, so the pass ends there.
        if (i_inc < n_use) begin
          state_nxt = S_RDI;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDI: begin
        state_nxt = S_LDI;
      end
      S_LDI: begin
        cur_nxt = ram_rdata;
        if (ram_rdata.collides) begin
          j_nxt     = i_inc;
          state_nxt = S_RDJ;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_ROW;
        end
      end
      S_RDJ: begin
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        oth_nxt = ram_rdata;
        sx_nxt  = dx[DIF_W-1];
        sy_nxt  = dy[DIF_W-1];
        mx_nxt  = dx[DIF_W-1] ? MUL_W'(-dx) : MUL_W'(dx);
        my_nxt  = dy[DIF_W-1] ? MUL_W'(-dy) : MUL_W'(dy);
        rs_nxt  = {1'b0, cur_r.radius} + {1'b0, ram_rdata.radius};
        if (ram_rdata.collides) begin
          state_nxt = S_SQX;
        end else if (j_inc < n_use) begin
          j_nxt     = j_inc;
          state_nxt = S_RDJ;
        end else begin
          state_nxt = S_WBI;
        end
      end
      S_SQX: begin
        state_nxt = S_SQY;
      end
      S_SQY: begin
        acc_nxt   = {1'b0, mul_p};
        state_nxt = S_SQR;
      end
      S_SQR: begin
        acc_nxt   = acc_r + {1'b0, mul_p};
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // The product now holds the squared radius sum.
        if (acc_r < {1'b0, mul_p}) begin
          state_nxt = S_GX;
        end else if (j_inc < n_use) begin
          j_nxt     = j_inc;
          state_nxt = S_RDJ;
        end else begin
          state_nxt = S_WBI;
        end
      end
      S_GX: begin
        px_nxt    = push_amt(mul_p, sx_r);
        state_nxt = S_GY;
      end
      S_GY: begin
        py_nxt    = push_amt(mul_p, sy_r);
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cur_nxt.pos_x   = xi_new;
        cur_nxt.pos_y   = yi_new;
        ram_we          = 1'b1;
        ram_waddr       = j_r[ADDR_W-1:0];
        ram_wdata       = oth_r;
        ram_wdata.pos_x = xj_new;
        ram_wdata.pos_y = yj_new;
        if (j_inc < n_use) begin
          j_nxt     = j_inc;
          state_nxt = S_RDJ;
        end else begin
          state_nxt = S_WBI;
        end
      end
      S_WBI: begin
        // Circle i stays in registers across its row and is written back once.
        ram_we    = 1'b1;
        ram_waddr = i_r[ADDR_W-1:0];
        ram_wdata = cur_r;
        i_nxt     = i_inc;
        state_nxt = S_ROW;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_index_nxt = '0;
        out_pos_x_nxt = '0;
        out_pos_y_nxt = '0;
        out_op_nxt    = OP_RELAX;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    cur_r       <= cur_nxt;
    oth_r       <= oth_nxt;
    mx_r        <= mx_nxt;
    my_r        <= my_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    rs_r        <= rs_nxt;
    acc_r       <= acc_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    out_index_r <= out_index_nxt;
    out_pos_x_r <= out_pos_x_nxt;
    out_pos_y_r <= out_pos_y_nxt;
    out_op_r    <= out_op_nxt;
  end

  cor_ram #(
    .WIDTH ($bits(circ_t)),
    .DEPTH (MAX_CIRCLES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  cor_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  assign out_valid   = out_valid_r;
  assign out_index   = out_index_r;
  assign out_pos_x   = out_pos_x_r;
  assign out_pos_y   = out_pos_y_r;
  assign out_op_done = out_op_r;

`ifndef SYNTHESIS
  // The partner of a pair always lies after the row circle.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDJ || state_r == S_DIFF || state_r == S_CMP || state_r == S_UPD)
    |-> (j_r > i_r))
    else $error("pair partner index not above row index");

  // No table read beyond the entries in use during a pass.
  a_j_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDJ) |-> (j_r < n_use))
    else $error("pair partner beyond circles in use");

  // The table is written only by a write beat, a pair update or a row write-back.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_UPD || state_r == S_WBI))
    else $error("table written from an unexpected state");

  // Only a read result carries a position.
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_op_r != OP_READ) |-> (out_pos_x_r == '0 && out_pos_y_r == '0))
    else $error("non-read result with nonzero position");
`endif

endmodule

@@ rtl/cor_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/cor_mul.sv @@
// Shared unsigned multiplier with a registered product.
module cor_mul (
  input  logic                         clk,
  input  logic [cor_pkg::MUL_W-1:0]    op_a,
  input  logic [cor_pkg::MUL_W-1:0]    op_b,
  output logic [cor_pkg::PROD_W-1:0]   prod
);
  import cor_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
